// ----- src/pas_pkg.sv -----
// Shared constants, types and helpers of the preferential attachment selector.
// No dependencies; pas_if, pas_mod, the selector and the bench refer to it by scoped names.
package pas_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int SEED_NODES = 3;

  localparam int IN_NODE_W = 10;                  // width of node fields on the ports
  localparam int RND_W     = 32;
  localparam int DEG_W     = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int TOT_W     = NODE_W + DEG_W + 1;  // sum of (degree + 1) over all nodes
  localparam int DIV_CNT_W = $clog2(RND_W);
  localparam int WT_W      = 32;

  localparam logic [DEG_W-1:0] DEG_MAX  = {DEG_W{1'b1}};
  localparam logic [DEG_W-1:0] SEED_DEG = DEG_W'(SEED_NODES - 1);

  typedef enum logic [1:0] {
    STAT_ATTACH = 2'd0,
    STAT_NONE   = 2'd1,
    STAT_CLEAR  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ACT_CLEAR  = 1'b0,
    ACT_ATTACH = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_BUMP_T,
    ST_WR_N,
    ST_DONE
  } state_t;

  function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
    deg_inc = (d == DEG_MAX) ? d : d + 1'b1;
  endfunction

endpackage

// ----- src/pas_if.sv -----
// Valid/ready channels of the selector: the input item and the result word.
// Depends on pas_pkg for field widths.
interface pas_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [pas_pkg::IN_NODE_W-1:0]  new_node;
  logic [pas_pkg::RND_W-1:0]      random_word;

  modport source (output valid, action, new_node, random_word, input ready);
  modport sink   (input valid, action, new_node, random_word, output ready);
endinterface

interface pas_out_if;
  logic                           valid;
  logic                           ready;
  logic [pas_pkg::IN_NODE_W-1:0]  target_node;
  logic [1:0]                     status;

  modport source (output valid, target_node, status, input ready);
  modport sink   (input valid, target_node, status, output ready);
endinterface

// ----- src/pas_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pas_mod.sv -----
// Restoring remainder unit: random word modulo the weight total, one bit a cycle.
// Depends on pas_pkg.
module pas_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pas_pkg::RND_W-1:0]   dividend,
  input  logic [pas_pkg::TOT_W-1:0]   divisor,
  output logic                        done,
  output logic [pas_pkg::TOT_W-1:0]   rem
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pas_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pas_pkg::RND_W-1:0]       dvd_r, dvd_nxt;
  logic [pas_pkg::TOT_W-1:0]       rem_r, rem_nxt;
  logic [pas_pkg::TOT_W:0]         trial;

  assign trial = {rem_r, dvd_r[pas_pkg::RND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[pas_pkg::RND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = pas_pkg::TOT_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[pas_pkg::TOT_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pas_pkg::DIV_CNT_W'(pas_pkg::RND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < divisor))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("remainder unit restarted while busy");

endmodule

// ----- src/preferential_attachment_selector.sv -----
// Preferential attachment selector: degree table in one RAM, weighted target draw.
// Depends on pas_pkg, pas_if, pas_ram and pas_mod.
//
// After reset the block sweeps the 1024-entry degree table once, one entry a cycle
// (in_ch.ready low), leaving zeros with the three seed nodes at degree two.
// A clear item runs the same sweep and then returns one word with status 2. An attach
// item for node n reads entries through the single RAM read port, one entry a cycle:
// first a pass over 0..n-1 for the weight total, then a cumulative walk that stops at
// the target, with a bit-serial modulo in between and the states ST_BUMP_T and ST_WR_N
// to bump both degrees. An attach with no eligible node goes straight to ST_DONE.
// A finished word waits in the output register while the next item is taken.
module preferential_attachment_selector (
  input  logic            clk,
  input  logic            rst_n,
  pas_in_if.sink          in_ch,
  pas_out_if.source       out_ch
);

  localparam int NW = pas_pkg::NODE_W;
  localparam int TW = pas_pkg::TOT_W;
  localparam int DW = pas_pkg::DEG_W;

  pas_pkg::state_t          st_r, st_nxt;
  logic [NW:0]              cnt_r, cnt_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [NW-1:0]            rd_idx_r, rd_idx_nxt;
  logic [NW-1:0]            node_r, node_nxt;
  logic [pas_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [TW-1:0]            acc_r, acc_nxt;
  logic [TW-1:0]            tot_r, tot_nxt;
  logic [NW-1:0]            tgt_r, tgt_nxt;
  logic [DW-1:0]            tdeg_r, tdeg_nxt;
  logic                     found_r, found_nxt;
  logic [pas_pkg::WT_W-1:0] wt_r, wt_nxt;
  logic                     clr_item_r, clr_item_nxt;
  logic [NW-1:0]            res_tgt_r, res_tgt_nxt;
  pas_pkg::status_t         res_stat_r, res_stat_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [NW-1:0]            out_tgt_r, out_tgt_nxt;
  pas_pkg::status_t         out_stat_r, out_stat_nxt;

  logic                     ram_we;
  logic [NW-1:0]            ram_waddr, ram_raddr;
  logic [DW-1:0]            ram_wdata, ram_rdata;
  logic                     div_start, div_done;
  logic [TW-1:0]            div_rem;
  logic                     in_ready, load_out, accept;
  logic                     issue, clr_last, bad_node;
  logic [TW-1:0]            cum;

  pas_ram #(.WIDTH(DW), .DEPTH(pas_pkg::MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pas_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (tot_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign accept   = in_ch.valid && in_ready;
  assign issue    = (cnt_r < {1'b0, node_r}) && !found_r;
  assign clr_last = (cnt_r == (NW+1)'(pas_pkg::MAX_NODES - 1));
  assign bad_node = (in_ch.new_node == '0) ||
                    (32'(in_ch.new_node) >= 32'(pas_pkg::MAX_NODES));
  assign cum      = acc_r + TW'(ram_rdata) + 1'b1;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pas_pkg::ST_CLR: begin
        if (clr_last) st_nxt = clr_item_r ? pas_pkg::ST_DONE : pas_pkg::ST_IDLE;
      end
      pas_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.action == pas_pkg::ACT_CLEAR) st_nxt = pas_pkg::ST_CLR;
          else if (bad_node)                      st_nxt = pas_pkg::ST_DONE;
          else                                    st_nxt = pas_pkg::ST_SUM;
        end
      end
      pas_pkg::ST_SUM: begin
        if (!issue && !rd_vld_r) st_nxt = pas_pkg::ST_DIV;
      end
      pas_pkg::ST_DIV: begin
        if (div_done) st_nxt = pas_pkg::ST_WALK;
      end
      pas_pkg::ST_WALK: begin
        if (found_r || (!issue && !rd_vld_r)) st_nxt = pas_pkg::ST_BUMP_T;
      end
      pas_pkg::ST_BUMP_T: st_nxt = pas_pkg::ST_WR_N;
      pas_pkg::ST_WR_N:   st_nxt = pas_pkg::ST_DONE;
      pas_pkg::ST_DONE: begin
        if (load_out) st_nxt = pas_pkg::ST_IDLE;
      end
      default: st_nxt = pas_pkg::ST_CLR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[NW-1:0];
    ram_wdata = '0;
    ram_raddr = cnt_r[NW-1:0];
    div_start = 1'b0;
    load_out  = 1'b0;
    case (st_r)
      pas_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = (cnt_r < (NW+1)'(pas_pkg::SEED_NODES)) ? pas_pkg::SEED_DEG : '0;
      end
      pas_pkg::ST_IDLE: in_ready = 1'b1;
      pas_pkg::ST_SUM: begin
        div_start = !issue && !rd_vld_r;
      end
      pas_pkg::ST_BUMP_T: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = pas_pkg::deg_inc(tdeg_r);
        ram_raddr = node_r;
      end
      pas_pkg::ST_WR_N: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = pas_pkg::deg_inc(ram_rdata);
      end
      pas_pkg::ST_DONE: load_out = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = cnt_r[NW-1:0];
    node_nxt     = node_r;
    rnd_nxt      = rnd_r;
    acc_nxt      = acc_r;
    tot_nxt      = tot_r;
    tgt_nxt      = tgt_r;
    tdeg_nxt     = tdeg_r;
    found_nxt    = found_r;
    wt_nxt       = wt_r;
    clr_item_nxt = clr_item_r;
    res_tgt_nxt  = res_tgt_r;
    res_stat_nxt = res_stat_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_tgt_nxt  = out_tgt_r;
    out_stat_nxt = out_stat_r;
    case (st_r)
      pas_pkg::ST_CLR: cnt_nxt = cnt_r + 1'b1;
      pas_pkg::ST_IDLE: begin
        cnt_nxt   = '0;
        acc_nxt   = '0;
        found_nxt = 1'b0;
        node_nxt  = NW'(in_ch.new_node);
        rnd_nxt   = in_ch.random_word;
        if (accept) begin
          res_tgt_nxt = '0;
          if (in_ch.action == pas_pkg::ACT_CLEAR) begin
            clr_item_nxt = 1'b1;
            wt_nxt       = '0;
            res_stat_nxt = pas_pkg::STAT_CLEAR;
          end else if (bad_node) begin
            res_stat_nxt = pas_pkg::STAT_NONE;
          end else begin
            res_stat_nxt = pas_pkg::STAT_ATTACH;
          end
        end
      end
      pas_pkg::ST_SUM: begin
        rd_vld_nxt = issue;
        if (issue)    cnt_nxt = cnt_r + 1'b1;
        if (rd_vld_r) acc_nxt = cum;
        if (!issue && !rd_vld_r) begin
          tot_nxt = acc_r;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      pas_pkg::ST_WALK: begin
        rd_vld_nxt = issue;
        if (issue) cnt_nxt = cnt_r + 1'b1;
        // first node whose running sum passes the remainder
        if (rd_vld_r && !found_r) begin
          acc_nxt = cum;
          if (div_rem < cum) begin
            found_nxt = 1'b1;
            tgt_nxt   = rd_idx_r;
            tdeg_nxt  = ram_rdata;
          end
        end
        if (found_r || (!issue && !rd_vld_r)) begin
          wt_nxt      = pas_pkg::WT_W'(tot_r);
          res_tgt_nxt = tgt_r;
        end
      end
      pas_pkg::ST_DONE: begin
        if (load_out) begin
          out_vld_nxt  = 1'b1;
          out_tgt_nxt  = res_tgt_r;
          out_stat_nxt = res_stat_r;
          clr_item_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= pas_pkg::ST_CLR;
      cnt_r      <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      wt_r       <= '0;
      clr_item_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      found_r    <= found_nxt;
      wt_r       <= wt_nxt;
      clr_item_r <= clr_item_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    node_r     <= node_nxt;
    rnd_r      <= rnd_nxt;
    acc_r      <= acc_nxt;
    tot_r      <= tot_nxt;
    tgt_r      <= tgt_nxt;
    tdeg_r     <= tdeg_nxt;
    res_tgt_r  <= res_tgt_nxt;
    res_stat_r <= res_stat_nxt;
    out_tgt_r  <= out_tgt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.target_node = pas_pkg::IN_NODE_W'(out_tgt_r);
  assign out_ch.status      = out_stat_r;

  a_tgt_eligible: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pas_pkg::ST_BUMP_T) |-> (tgt_r < node_r))
    else $error("target not below new node");

  a_walk_found: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pas_pkg::ST_BUMP_T) |-> found_r)
    else $error("walk ended without a target");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pas_pkg::ST_SUM || st_r == pas_pkg::ST_WALK) |-> !ram_we)
    else $error("table written during a scan");

  a_cum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pas_pkg::ST_WALK) |-> (acc_r <= tot_r))
    else $error("running sum above weight total");

  a_total_set: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == pas_pkg::ST_WR_N) |-> (wt_r != '0))
    else $error("weight total zero after attach");

endmodule

// ----- verif/preferential_attachment_selector_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the preferential attachment selector: drives attach and clear
// words, predicts each target draw from its own degree table and checks every result.
// Depends on pas_pkg, pas_if and the selector RTL.
module preferential_attachment_selector_test;

  localparam int HOLD_AT     = 40;                // results seen before the long receiver hold
  localparam int HOLD_CYCLES = 800;
  localparam int TAIL_AT     = 480;               // no idling on either side past this point
  localparam int GROW_CAP    = 160;               // growth runs restart with a clear here
  localparam int LATE_CYCLES = 2 * pas_pkg::MAX_NODES + 64;

  typedef struct packed {
    pas_pkg::action_t                act;
    logic [pas_pkg::IN_NODE_W-1:0]   node;
    logic [pas_pkg::RND_W-1:0]       word;
  } attach_req_t;

  typedef struct packed {
    logic [pas_pkg::IN_NODE_W-1:0]   target;
    pas_pkg::status_t                status;
  } draw_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pas_in_if  in_ch();
  pas_out_if out_ch();

  preferential_attachment_selector u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  attach_req_t    req_q[$];
  draw_result_t   draw_q[$];
  logic [pas_pkg::DEG_W-1:0] degree_of [pas_pkg::MAX_NODES];

  int items_sent = 0;
  int words_got  = 0;
  int fault_cnt  = 0;
  int grow_at    = pas_pkg::SEED_NODES;
  int gap_left   = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // ---------------- predictor ----------------

  function automatic void reseed_degrees();
    for (int i = 0; i < pas_pkg::MAX_NODES; i++)
      degree_of[i] = (i < pas_pkg::SEED_NODES) ?
                     pas_pkg::DEG_W'(pas_pkg::SEED_NODES - 1) : '0;
  endfunction

  function automatic void raise_degree(input int idx);
    if (degree_of[idx] != pas_pkg::DEG_MAX)
      degree_of[idx] = degree_of[idx] + 1'b1;
  endfunction

  function automatic draw_result_t pick_target(input pas_pkg::action_t act,
                                               input logic [pas_pkg::IN_NODE_W-1:0] node,
                                               input logic [pas_pkg::RND_W-1:0] word);
    draw_result_t res;
    logic [63:0]  total;
    logic [63:0]  draw;
    logic [63:0]  run;
    int           hit;
    bit           found;
    res.target = '0;
    if (act == pas_pkg::ACT_CLEAR) begin
      reseed_degrees();
      res.status = pas_pkg::STAT_CLEAR;
    end else if (node == 0 || int'(node) >= pas_pkg::MAX_NODES) begin
      res.status = pas_pkg::STAT_NONE;
    end else begin
      total = '0;
      for (int i = 0; i < node; i++)
        total = total + degree_of[i] + 64'd1;
      draw  = {32'd0, word} % total;
      run   = '0;
      hit   = 0;
      found = 1'b0;
      for (int i = 0; i < node; i++) begin
        run = run + degree_of[i] + 64'd1;
        if (!found && draw < run) begin
          hit   = i;
          found = 1'b1;
        end
      end
      // new node first, then the target; both clamp at the top degree
      raise_degree(int'(node));
      raise_degree(hit);
      res.target = pas_pkg::IN_NODE_W'(hit);
      res.status = pas_pkg::STAT_ATTACH;
    end
    return res;
  endfunction

  // ---------------- stimulus ----------------

  task automatic queue_item(input pas_pkg::action_t act, input int node,
                            input logic [pas_pkg::RND_W-1:0] word);
    attach_req_t req;
    req.act  = act;
    req.node = pas_pkg::IN_NODE_W'(node);
    req.word = word;
    req_q.push_back(req);
  endtask

  // Mostly growth runs (clear, then nodes 3, 4, 5 ... with one or more edges each),
  // the rest small and large random nodes, no-eligible attaches and stray clears.
  task automatic queue_random(input int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        queue_item(pas_pkg::ACT_CLEAR, $urandom_range(0, pas_pkg::MAX_NODES - 1), $urandom);
        grow_at = pas_pkg::SEED_NODES;
      end else if (roll < 7) begin
        queue_item(pas_pkg::ACT_ATTACH, 0, $urandom);
      end else if (roll < 11) begin
        queue_item(pas_pkg::ACT_ATTACH, $urandom_range(64, pas_pkg::MAX_NODES - 1), $urandom);
      end else if (roll < 28) begin
        queue_item(pas_pkg::ACT_ATTACH, $urandom_range(1, 63), $urandom);
      end else begin
        if (grow_at >= GROW_CAP) begin
          queue_item(pas_pkg::ACT_CLEAR, $urandom_range(0, pas_pkg::MAX_NODES - 1),
                     $urandom);
          grow_at = pas_pkg::SEED_NODES;
        end
        queue_item(pas_pkg::ACT_ATTACH, grow_at, $urandom);
        if ($urandom_range(0, 2) != 0)
          grow_at++;
      end
    end
  endtask

  // sampled at the falling edge, once the rising-edge updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (req_q.size() != 0 || in_ch.valid || words_got != items_sent)
      @(negedge clk);
  endtask

  // ---------------- checking ----------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fault_cnt++;
  endtask

  // ---------------- sender ----------------

  always @(posedge clk) begin
    attach_req_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        draw_q.push_back(pick_target(pas_pkg::action_t'(in_ch.action), in_ch.new_node,
                                     in_ch.random_word));
        items_sent <= items_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (items_sent < TAIL_AT && req_q.size() != 0 &&
                     $urandom_range(0, 5) == 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= $urandom_range(1, 19) - 1;
        end else if (req_q.size() != 0) begin
          nxt = req_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.action      <= nxt.act;
          in_ch.new_node    <= nxt.node;
          in_ch.random_word <= nxt.word;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------

  always @(posedge clk) begin
    draw_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_got <= words_got + 1;
        if (draw_q.size() == 0) begin
          flag_mismatch("unexpected word, status", out_ch.status, -1);
        end else begin
          want = draw_q.pop_front();
          if (out_ch.target_node !== want.target)
            flag_mismatch("target_node", out_ch.target_node, want.target);
          if (out_ch.status !== want.status)
            flag_mismatch("status", out_ch.status, want.status);
        end
      end
      // one long hold while the sender keeps offering, so the block backs up
      if (!hold_done && words_got == HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (words_got < TAIL_AT && $urandom_range(0, 15) == 0) begin
        stall_left   <= $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = pas_pkg::ACT_CLEAR;
    in_ch.new_node    = '0;
    in_ch.random_word = '0;
    out_ch.ready      = 1'b0;
    reseed_degrees();

    // directed: no eligible node, single-node table, seed core, top node and word
    // extremes, clears with junk fields. Degree saturation needs 65535 bumps of one
    // node, far past this run; the predictor still clamps.
    queue_item(pas_pkg::ACT_ATTACH, 0, 32'h0000_0000);
    queue_item(pas_pkg::ACT_ATTACH, 0, 32'hFFFF_FFFF);
    queue_item(pas_pkg::ACT_ATTACH, 1, 32'h0000_0000);
    queue_item(pas_pkg::ACT_ATTACH, 1, 32'hFFFF_FFFF);
    queue_item(pas_pkg::ACT_ATTACH, 3, 32'd0);
    queue_item(pas_pkg::ACT_ATTACH, 3, 32'd2);
    queue_item(pas_pkg::ACT_ATTACH, 3, 32'd3);
    queue_item(pas_pkg::ACT_ATTACH, 3, 32'hFFFF_FFFF);
    queue_item(pas_pkg::ACT_ATTACH, 2, 32'd5);
    queue_item(pas_pkg::ACT_ATTACH, pas_pkg::MAX_NODES - 1, 32'h0000_0000);
    queue_item(pas_pkg::ACT_ATTACH, pas_pkg::MAX_NODES - 1, 32'hFFFF_FFFF);
    queue_item(pas_pkg::ACT_ATTACH, 10'h200, 32'h8000_0000);
    queue_item(pas_pkg::ACT_ATTACH, 10'h2AA, 32'hAAAA_AAAA);
    queue_item(pas_pkg::ACT_ATTACH, 10'h155, 32'h5555_5555);
    queue_item(pas_pkg::ACT_CLEAR, pas_pkg::MAX_NODES - 1, 32'hFFFF_FFFF);
    queue_item(pas_pkg::ACT_ATTACH, 4, 32'd7);
    queue_item(pas_pkg::ACT_CLEAR, 0, 32'd0);
    queue_item(pas_pkg::ACT_ATTACH, 3, 32'd8);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    queue_random(260);
    wait_drained();

    // sender held back until the block has answered everything
    repeat ($urandom_range(5, 40)) @(posedge clk);
    @(negedge clk);
    queue_random(262);
    wait_drained();

    repeat (LATE_CYCLES) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
src/pas_pkg.sv
src/pas_if.sv
src/pas_ram.sv
src/pas_mod.sv
src/preferential_attachment_selector.sv
verif/preferential_attachment_selector_test.sv
